// ===== hdl/elgs_pkg.sv =====
// Package for the edge list graph store: request and response types, codes, defaults.
package elgs_pkg;

   localparam int MAX_EDGES_DEFAULT   = 64;
   localparam int VERTEX_BITS_DEFAULT = 8;
   localparam int VERTEX_WIDTH        = 8;
   localparam int DEGREE_WIDTH        = 7;

   typedef enum logic [1:0] {
      ACTION_CLEAR = 2'd0,
      ACTION_ADD   = 2'd1,
      ACTION_QUERY = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [1:0]              action;
      logic [VERTEX_WIDTH-1:0] vertex_a;
      logic [VERTEX_WIDTH-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic [VERTEX_WIDTH-1:0] neighbour;
      logic                    has_neighbour;
      logic [DEGREE_WIDTH-1:0] degree_count;
      logic                    is_adjacent;
      logic                    add_dropped;
      logic                    last;
   } rsp_type;

endpackage

// ===== hdl/edge_list_graph_store_core.sv =====
// Edge list graph store: edge memory, scan sequencer and response register.
//
// Requests arrive on req_valid/req_data and are taken when req_stall is low.
// Responses leave on rsp_valid/rsp_data and are held while rsp_stall is high.
// A request is clear, add (append the pair a,b) or query (list the edges
// touching vertex a). Each clear, add or unused code puts one response in the
// response register from the execute state once the register is free, then
// returns to idle to take the next request; an add to a full list is flagged with
// add_dropped. A query gives one response per matching edge in list order,
// the last one carrying the degree and the a-b adjacency; with no match it
// gives one response without a neighbour.
// A query reads one edge per cycle through the single read port of the edge
// memory while the response side does not hold it up; its last response is
// loaded from the final state once the scan ends and the register is free.
// One request is worked on at a time; req_stall is high until the last
// response of the current request sits in the response register.
// A stall on the response side holds the register and pauses the scan.
// Reset empties the edge list and drops any request in flight; the edge
// memory itself is not cleared, entries past the count are never read.
module edge_list_graph_store_core #(
   parameter int MAX_EDGES   = elgs_pkg::MAX_EDGES_DEFAULT,
   parameter int VERTEX_BITS = elgs_pkg::VERTEX_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  elgs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output elgs_pkg::rsp_type rsp_data
);
   import elgs_pkg::*;

   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int VB = VERTEX_BITS;

   logic [2*VB-1:0] edge_mem [MAX_EDGES];
   logic [2*VB-1:0] rdata_ff;

   state_type     state_ff, state_in;
   req_type       item_ff, item_in;
   logic [CW-1:0] edge_count_ff, edge_count_in;
   logic [CW-1:0] issue_idx_ff, issue_idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [VB-1:0] pend_nb_ff, pend_nb_in;
   logic [CW-1:0] deg_ff, deg_in;
   logic          adj_ff, adj_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          out_free, load;
   rsp_type       new_rsp;
   logic          mem_we, rd_en;
   logic [VB-1:0] qa, qb, m_u, m_v, other;
   logic          hit_u, hit_v, hit, adj_hit, need_emit, consume, more;

   assign qa       = VB'(item_ff.vertex_a);
   assign qb       = VB'(item_ff.vertex_b);
   assign m_u      = rdata_ff[2*VB-1:VB];
   assign m_v      = rdata_ff[VB-1:0];
   assign hit_u    = (m_u == qa);
   assign hit_v    = (m_v == qa);
   assign hit      = hit_u | hit_v;
   assign other    = hit_u ? m_v : m_u;
   assign adj_hit  = (hit_u && m_v == qb) || (m_u == qb && hit_v);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign more     = (issue_idx_ff < edge_count_ff);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      edge_count_in = edge_count_ff;
      issue_idx_in  = issue_idx_ff;
      rd_valid_in   = rd_valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_nb_in    = pend_nb_ff;
      deg_in        = deg_ff;
      adj_in        = adj_ff;
      load          = 1'b0;
      new_rsp       = '0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      need_emit     = 1'b0;
      consume       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (action_type'(item_ff.action))
               ACTION_QUERY: begin
                  issue_idx_in  = '0;
                  deg_in        = '0;
                  adj_in        = 1'b0;
                  pend_valid_in = 1'b0;
                  rd_valid_in   = 1'b0;
                  state_in      = ST_SCAN;
               end
               ACTION_ADD: begin
                  if (out_free) begin
                     load         = 1'b1;
                     new_rsp.last = 1'b1;
                     if (edge_count_ff == CW'(MAX_EDGES)) begin
                        new_rsp.add_dropped = 1'b1;
                     end else begin
                        mem_we        = 1'b1;
                        edge_count_in = edge_count_ff + 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
               end
               ACTION_CLEAR: begin
                  if (out_free) begin
                     load          = 1'b1;
                     new_rsp.last  = 1'b1;
                     edge_count_in = '0;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     load         = 1'b1;
                     new_rsp.last = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            need_emit = hit && pend_valid_ff;
            consume   = rd_valid_ff && (!need_emit || out_free);
            if (consume) begin
               if (adj_hit) begin
                  adj_in = 1'b1;
               end
               if (hit) begin
                  deg_in        = deg_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_nb_in    = other;
               end
               if (need_emit) begin
                  load                  = 1'b1;
                  new_rsp.neighbour     = VERTEX_WIDTH'(pend_nb_ff);
                  new_rsp.has_neighbour = 1'b1;
               end
            end
            if (more && (!rd_valid_ff || consume)) begin
               rd_en        = 1'b1;
               issue_idx_in = issue_idx_ff + 1'b1;
               rd_valid_in  = 1'b1;
            end else if (consume) begin
               rd_valid_in = 1'b0;
            end
            if (!more && (!rd_valid_ff || consume)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               load                  = 1'b1;
               new_rsp.neighbour     = pend_valid_ff ? VERTEX_WIDTH'(pend_nb_ff) : '0;
               new_rsp.has_neighbour = pend_valid_ff;
               new_rsp.degree_count  = DEGREE_WIDTH'(deg_ff);
               new_rsp.is_adjacent   = adj_ff;
               new_rsp.last          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_data_in  = load ? new_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         edge_mem[edge_count_ff[AW-1:0]] <= {VB'(item_ff.vertex_a), VB'(item_ff.vertex_b)};
      end
      if (rd_en) begin
         rdata_ff <= edge_mem[issue_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_count_ff <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff      <= item_in;
      issue_idx_ff <= issue_idx_in;
      pend_nb_ff   <= pend_nb_in;
      deg_ff       <= deg_in;
      adj_ff       <= adj_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= CW'(MAX_EDGES))
      else $error("edge count past capacity");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == ST_SCAN)
      else $error("read data pending outside scan");

   a_deg_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> deg_ff <= issue_idx_ff && issue_idx_ff <= edge_count_ff)
      else $error("degree or scan index out of range");

   a_drop_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.add_dropped |-> rsp_data.last && !rsp_data.has_neighbour)
      else $error("dropped add response malformed");

endmodule

// ===== dv/edge_list_graph_store_core_tb.sv =====
// Testbench for edge_list_graph_store_core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module edge_list_graph_store_core_tb;
   import elgs_pkg::*;

   localparam int         EDGE_SLOTS    = MAX_EDGES_DEFAULT;
   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam int         IDLE_LIMIT    = 5000;
   localparam int         TAIL_CYCLES   = EDGE_SLOTS + 10;
   localparam int         MAX_REPORTS   = 10;
   localparam int         HOLD_CYCLES   = 150;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [VERTEX_WIDTH-1:0] edge_u [EDGE_SLOTS];
   logic [VERTEX_WIDTH-1:0] edge_v [EDGE_SLOTS];
   logic [VERTEX_WIDTH-1:0] vertex_pool [4];
   int      stored_edges   = 0;
   rsp_type expected_rsp [$];
   int      mismatch_count = 0;
   int      requests_sent  = 0;
   int      send_idle_pct  = 0;
   int      stall_pct      = 0;
   int      hold_left      = 0;
   int      idle_cycles    = 0;

   edge_list_graph_store_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic string rsp_text(rsp_type r);
      return $sformatf("nb=%0d has=%0b deg=%0d adj=%0b drop=%0b last=%0b",
                       r.neighbour, r.has_neighbour, r.degree_count,
                       r.is_adjacent, r.add_dropped, r.last);
   endfunction

   // Updates the edge list copy and queues the responses one request gives.
   function automatic void predict_graph_request(req_type r);
      rsp_type res;
      rsp_type hit;
      int      deg;
      bit      adj;
      bit      have_hit;
      res      = '0;
      hit      = '0;
      deg      = 0;
      adj      = 1'b0;
      have_hit = 1'b0;
      case (r.action)
         ACTION_CLEAR: stored_edges = 0;
         ACTION_ADD: begin
            if (stored_edges >= EDGE_SLOTS) begin
               res.add_dropped = 1'b1;
            end else begin
               edge_u[stored_edges] = r.vertex_a;
               edge_v[stored_edges] = r.vertex_b;
               stored_edges++;
            end
         end
         ACTION_QUERY: begin
            for (int i = 0; i < stored_edges; i++) begin
               if ((edge_u[i] == r.vertex_a && edge_v[i] == r.vertex_b) ||
                   (edge_u[i] == r.vertex_b && edge_v[i] == r.vertex_a))
                  adj = 1'b1;
               if (edge_u[i] == r.vertex_a || edge_v[i] == r.vertex_a) begin
                  if (have_hit)
                     expected_rsp.push_back(hit);
                  hit = '0;
                  hit.has_neighbour = 1'b1;
                  hit.neighbour = (edge_u[i] == r.vertex_a) ? edge_v[i] : edge_u[i];
                  have_hit = 1'b1;
                  deg++;
               end
            end
            if (have_hit)
               res = hit;
            res.degree_count = deg[DEGREE_WIDTH-1:0];
            res.is_adjacent  = adj;
         end
         default: ;
      endcase
      res.last = 1'b1;
      expected_rsp.push_back(res);
   endfunction

   task automatic send_request(input logic [1:0] action,
                               input logic [VERTEX_WIDTH-1:0] a,
                               input logic [VERTEX_WIDTH-1:0] b);
      req_type r;
      r.action   = action;
      r.vertex_a = a;
      r.vertex_b = b;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_graph_request(r);
      requests_sent++;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VERTEX_WIDTH-1:0] pick_vertex();
      if ($urandom_range(99) < 80)
         return vertex_pool[$urandom_range(3)];
      return VERTEX_WIDTH'($urandom_range(255));
   endfunction

   task automatic test_directed_cases();
      send_request(ACTION_QUERY, 8'd0, 8'd0);
      send_request(ACTION_UNUSED, 8'd255, 8'd255);
      send_request(ACTION_ADD, 8'd0, 8'd255);
      send_request(ACTION_ADD, 8'd255, 8'd0);
      send_request(ACTION_ADD, 8'd7, 8'd7);
      send_request(ACTION_ADD, 8'd255, 8'd255);
      send_request(ACTION_ADD, 8'd128, 8'd1);
      send_request(ACTION_QUERY, 8'd255, 8'd0);
      send_request(ACTION_QUERY, 8'd0, 8'd255);
      // self loop yields its vertex once
      send_request(ACTION_QUERY, 8'd7, 8'd7);
      send_request(ACTION_QUERY, 8'd7, 8'd8);
      send_request(ACTION_QUERY, 8'd1, 8'd128);
      send_request(ACTION_QUERY, 8'd100, 8'd255);
      send_request(ACTION_CLEAR, 8'd0, 8'd0);
      send_request(ACTION_QUERY, 8'd255, 8'd0);
      send_request(ACTION_UNUSED, 8'd0, 8'd0);
      wait_for_responses();
   endtask

   // Every edge touches one hub, so the hub query gives the most responses.
   task automatic test_full_list();
      logic [VERTEX_WIDTH-1:0] hub;
      logic [VERTEX_WIDTH-1:0] other;
      logic [VERTEX_WIDTH-1:0] partner;
      hub     = VERTEX_WIDTH'($urandom_range(255));
      partner = hub;
      send_request(ACTION_CLEAR, VERTEX_WIDTH'($urandom_range(255)),
                   VERTEX_WIDTH'($urandom_range(255)));
      for (int i = 0; i < EDGE_SLOTS; i++) begin
         other = ($urandom_range(15) == 0) ? hub : VERTEX_WIDTH'($urandom_range(255));
         if (i == EDGE_SLOTS / 2)
            partner = other;
         if ($urandom_range(1))
            send_request(ACTION_ADD, hub, other);
         else
            send_request(ACTION_ADD, other, hub);
      end
      send_request(ACTION_ADD, VERTEX_WIDTH'($urandom_range(255)),
                   VERTEX_WIDTH'($urandom_range(255)));
      send_request(ACTION_ADD, hub, hub);
      send_request(ACTION_QUERY, hub, partner);
      send_request(ACTION_QUERY, partner, hub);
      send_request(ACTION_QUERY, hub, VERTEX_WIDTH'($urandom_range(255)));
      send_request(ACTION_QUERY, ~hub, hub);
      wait_for_responses();
   endtask

   task automatic test_backpressure();
      logic [VERTEX_WIDTH-1:0] hub;
      hub       = VERTEX_WIDTH'($urandom_range(255));
      hold_left = HOLD_CYCLES;
      send_request(ACTION_CLEAR, 8'd0, 8'd0);
      for (int i = 0; i < 6; i++)
         send_request(ACTION_ADD, hub, VERTEX_WIDTH'($urandom_range(255)));
      send_request(ACTION_QUERY, hub, VERTEX_WIDTH'($urandom_range(255)));
      send_request(ACTION_QUERY, hub, hub);
      wait_for_responses();
   endtask

   task automatic test_random_sequences(input int budget);
      int first;
      int adds;
      first = requests_sent;
      while (requests_sent - first < budget) begin
         for (int k = 0; k < 4; k++)
            vertex_pool[k] = VERTEX_WIDTH'($urandom_range(255));
         if ($urandom_range(99) < 85) begin
            if ($urandom_range(99) < 70)
               send_request(ACTION_CLEAR, pick_vertex(), pick_vertex());
            adds = $urandom_range(1, 12);
            for (int i = 0; i < adds; i++)
               send_request(ACTION_ADD, pick_vertex(), pick_vertex());
            for (int i = $urandom_range(1, 4); i > 0; i--)
               send_request(ACTION_QUERY, pick_vertex(), pick_vertex());
         end else begin
            for (int i = $urandom_range(1, 5); i > 0; i--)
               send_request(2'($urandom_range(3)), VERTEX_WIDTH'($urandom_range(255)),
                            VERTEX_WIDTH'($urandom_range(255)));
         end
      end
      wait_for_responses();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: %s", rsp_text(rsp_data));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.neighbour     !== want.neighbour     ||
                rsp_data.has_neighbour !== want.has_neighbour ||
                rsp_data.degree_count  !== want.degree_count  ||
                rsp_data.is_adjacent   !== want.is_adjacent   ||
                rsp_data.add_dropped   !== want.add_dropped   ||
                rsp_data.last          !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("response mismatch: expected %s, got %s",
                           rsp_text(want), rsp_text(rsp_data));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", IDLE_LIMIT);
         $display("edge_list_graph_store_core_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_full_list();
      test_backpressure();

      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_sequences(32);
      send_idle_pct = 52;
      stall_pct     = 0;
      test_random_sequences(32);
      send_idle_pct = 0;
      stall_pct     = 52;
      test_random_sequences(32);
      send_idle_pct = 35;
      stall_pct     = 35;
      test_random_sequences(32);

      wait_for_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("edge_list_graph_store_core_tb: PASS");
      else
         $display("edge_list_graph_store_core_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/elgs_pkg.sv
hdl/edge_list_graph_store_core.sv
dv/edge_list_graph_store_core_tb.sv
